@@ hdl/mtf_pkg.sv @@
package mtf_pkg;

    // Frame buffer geometry
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
    localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int NIB_W           = LEN_W + 1;

    // Configuration register widths
    localparam int MIN_LEN_W = 12;
    localparam int PRE_W     = 6;
    localparam int GAP_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    // Command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP        = 2'd2;

    // Configuration reset values
    localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RST = 12'd60;
    localparam logic [PRE_W-1:0]     PREAMBLE_RST   = 6'd15;
    localparam logic [GAP_W-1:0]     GAP_RST        = 8'd24;

    // MII symbols
    localparam logic [3:0] NIB_PREAMBLE = 4'h5;
    localparam logic [3:0] NIB_SFD      = 4'hD;

    // Reflected Ethernet CRC-32
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam int          CRC_NIBS = 8;

    typedef struct packed {
        logic [MIN_LEN_W-1:0] min_length;
        logic [PRE_W-1:0]     preamble_nibbles;
        logic [GAP_W-1:0]     gap_nibbles;
    } cfg_t;

    typedef struct packed {
        logic wr;
        logic clr;
    } buf_ctrl_t;

    // Fold one byte into the CRC, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in;
        for (int k = 0; k < 8; k++) begin
            if ((c[0] ^ b[k]) == 1'b1)
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

@@ hdl/mtf_frame_buf.sv @@
module mtf_frame_buf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mtf_pkg::buf_ctrl_t          ctrl,
    input  logic [7:0]                  wdata,
    input  logic [mtf_pkg::ADDR_W-1:0]  rd_addr,
    output logic [7:0]                  rd_data,
    output logic [mtf_pkg::LEN_W-1:0]   loaded_count
);

    logic [7:0]                mem [mtf_pkg::MAX_FRAME_BYTES];
    logic [mtf_pkg::LEN_W-1:0] count_reg;
    logic [mtf_pkg::LEN_W-1:0] count_next;
    logic                      wr_ok;
    logic [7:0]                rd_data_reg;

    // Accept a byte only while room remains
    assign wr_ok = ctrl.wr
                   && (count_reg < mtf_pkg::LEN_W'(mtf_pkg::MAX_FRAME_BYTES));

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clr)
            count_next = '0;
        else if (wr_ok)
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Write at the fill pointer
    always_ff @(posedge clk)
    begin
        if (wr_ok)
            mem[count_reg[mtf_pkg::ADDR_W-1:0]] <= wdata;
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data      = rd_data_reg;
    assign loaded_count = count_reg;

endmodule

@@ hdl/mtf_tx_seq.sv @@
module mtf_tx_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [1:0]                  cmd,
    input  mtf_pkg::cfg_t               cfg,
    input  logic [mtf_pkg::LEN_W-1:0]   loaded_count,
    input  logic [7:0]                  rd_data,
    output logic [mtf_pkg::ADDR_W-1:0]  rd_addr,
    output logic                        phase_idle,
    output logic                        buf_clr,
    output logic                        busy,
    output logic                        done,
    output logic                        tx_en,
    output logic [3:0]                  txd,
    output logic                        busy_res,
    output logic                        frame_end
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_SFD,
        PH_DATA,
        PH_CRC,
        PH_GAP
    } phase_t;

    typedef enum logic {
        S_WAIT,
        S_EXEC
    } fsm_t;

    fsm_t                      fsm_reg, fsm_next;
    phase_t                    phase_reg, phase_next;
    logic [mtf_pkg::NIB_W-1:0] nc_reg, nc_next;
    logic [mtf_pkg::LEN_W-1:0] flen_reg, flen_next;
    logic [31:0]               crc_reg, crc_next;
    logic                      done_reg, done_next;
    logic                      en_reg, en_next;
    logic [3:0]                txd_reg, txd_next;
    logic                      bres_reg, bres_next;
    logic                      end_reg, end_next;

    phase_t                    ph_v;
    logic [mtf_pkg::NIB_W-1:0] nc_v;
    logic [mtf_pkg::NIB_W-1:0] nc_inc;
    logic [7:0]                byte_v;
    logic [31:0]               crc_inv;
    logic [mtf_pkg::NIB_W-1:0] pre_ext;
    logic [mtf_pkg::NIB_W-1:0] gap_ext;
    logic [mtf_pkg::NIB_W-1:0] data_nibs;
    logic                      clr;

    // Byte address follows the nibble counter; data arrives in the execute cycle
    assign rd_addr   = nc_reg[mtf_pkg::ADDR_W:1];
    assign pre_ext   = mtf_pkg::NIB_W'(cfg.preamble_nibbles);
    assign gap_ext   = mtf_pkg::NIB_W'(cfg.gap_nibbles);
    assign data_nibs = {flen_reg, 1'b0};
    assign crc_inv   = ~crc_reg;

    always_comb
    begin
        fsm_next   = fsm_reg;
        phase_next = phase_reg;
        nc_next    = nc_reg;
        flen_next  = flen_reg;
        crc_next   = crc_reg;
        done_next  = 1'b0;
        en_next    = en_reg;
        txd_next   = txd_reg;
        bres_next  = bres_reg;
        end_next   = end_reg;
        clr        = 1'b0;
        ph_v       = phase_reg;
        nc_v       = nc_reg;
        nc_inc     = nc_reg + 1'b1;
        byte_v     = '0;

        case (fsm_reg)
            S_WAIT:
            begin
                if (accept) begin
                    // Latch the padded length and arm the preamble
                    if (cmd == mtf_pkg::CMD_START && phase_reg == PH_IDLE) begin
                        flen_next  = (loaded_count > mtf_pkg::LEN_W'(cfg.min_length))
                                     ? loaded_count : mtf_pkg::LEN_W'(cfg.min_length);
                        crc_next   = mtf_pkg::CRC_INIT;
                        nc_next    = '0;
                        phase_next = PH_PRE;
                    end else if (cmd == mtf_pkg::CMD_TICK) begin
                        fsm_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                // Produce one nibble time
                fsm_next  = S_WAIT;
                done_next = 1'b1;
                en_next   = 1'b0;
                txd_next  = '0;
                bres_next = 1'b0;
                end_next  = 1'b0;
                if (phase_reg != PH_IDLE) begin
                    bres_next = 1'b1;
                    if (phase_reg == PH_PRE && nc_reg >= pre_ext) begin
                        ph_v = PH_SFD;
                        nc_v = '0;
                    end
                    nc_inc = nc_v + 1'b1;
                    case (ph_v)
                        PH_PRE:
                        begin
                            en_next  = 1'b1;
                            txd_next = mtf_pkg::NIB_PREAMBLE;
                            nc_next  = nc_inc;
                            if (nc_inc >= pre_ext) begin
                                phase_next = PH_SFD;
                                nc_next    = '0;
                            end
                        end
                        PH_SFD:
                        begin
                            en_next    = 1'b1;
                            txd_next   = mtf_pkg::NIB_SFD;
                            nc_next    = '0;
                            phase_next = (flen_reg == '0) ? PH_CRC : PH_DATA;
                        end
                        PH_DATA:
                        begin
                            // Pad with zeros past the loaded bytes
                            byte_v  = (nc_v[mtf_pkg::NIB_W-1:1] < loaded_count)
                                      ? rd_data : 8'h00;
                            en_next = 1'b1;
                            if (nc_v[0] == 1'b0) begin
                                txd_next = byte_v[3:0];
                                crc_next = mtf_pkg::crc_byte(crc_reg, byte_v);
                            end else begin
                                txd_next = byte_v[7:4];
                            end
                            nc_next = nc_inc;
                            if (nc_inc >= data_nibs) begin
                                phase_next = PH_CRC;
                                nc_next    = '0;
                            end
                        end
                        PH_CRC:
                        begin
                            en_next  = 1'b1;
                            txd_next = crc_inv[{nc_v[2:0], 2'b00} +: 4];
                            nc_next  = nc_inc;
                            if (nc_inc >= mtf_pkg::NIB_W'(mtf_pkg::CRC_NIBS)) begin
                                if (cfg.gap_nibbles == '0) begin
                                    end_next = 1'b1;
                                    clr      = 1'b1;
                                end else begin
                                    phase_next = PH_GAP;
                                    nc_next    = '0;
                                end
                            end
                        end
                        default:
                        begin
                            // Idle gap with tx_en low
                            nc_next = nc_inc;
                            if (nc_inc >= gap_ext) begin
                                end_next = 1'b1;
                                clr      = 1'b1;
                            end
                        end
                    endcase
                    if (clr) begin
                        phase_next = PH_IDLE;
                        nc_next    = '0;
                        crc_next   = mtf_pkg::CRC_INIT;
                    end
                end
            end

            default:
            begin
                fsm_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fsm_reg   <= S_WAIT;
            phase_reg <= PH_IDLE;
            nc_reg    <= '0;
            flen_reg  <= '0;
            crc_reg   <= mtf_pkg::CRC_INIT;
            done_reg  <= 1'b0;
            en_reg    <= 1'b0;
            txd_reg   <= '0;
            bres_reg  <= 1'b0;
            end_reg   <= 1'b0;
        end else begin
            fsm_reg   <= fsm_next;
            phase_reg <= phase_next;
            nc_reg    <= nc_next;
            flen_reg  <= flen_next;
            crc_reg   <= crc_next;
            done_reg  <= done_next;
            en_reg    <= en_next;
            txd_reg   <= txd_next;
            bres_reg  <= bres_next;
            end_reg   <= end_next;
        end
    end

    assign phase_idle = (phase_reg == PH_IDLE);
    assign buf_clr    = clr;
    assign busy       = (fsm_reg == S_EXEC);
    assign done       = done_reg;
    assign tx_en      = en_reg;
    assign txd        = txd_reg;
    assign busy_res   = bres_reg;
    assign frame_end  = end_reg;

endmodule

@@ hdl/mii_transmit_framer_crc32.sv @@
// MII transmit framer with Ethernet CRC-32. Issue a transaction with start high
// while busy is low. A load transaction appends data_byte to the frame buffer
// (dropped when full or while a frame is on the wire); a start transaction latches
// the padded length and arms the preamble. A tick transaction produces one nibble
// time: busy is high for one cycle while the frame buffer is read, and the result
// appears on tx_en, txd, busy_res and frame_end, held until the next tick; done
// is high for exactly one cycle. The tick waits on the registered read of the
// frame buffer memory. The receiver cannot stall: capture each result in the
// cycle that done is high. Configuration writes (cfg_we, cfg_idx, cfg_wdata)
// take effect at once and are to be made while no frame is in progress.
module mii_transmit_framer_crc32 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      cmd,
    input  logic [7:0]                      data_byte,
    input  logic                            cfg_we,
    input  logic [mtf_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [mtf_pkg::CFG_W-1:0]       cfg_wdata,
    output logic                            done,
    output logic                            tx_en,
    output logic [3:0]                      txd,
    output logic                            busy_res,
    output logic                            frame_end
);

    mtf_pkg::cfg_t              cfg_reg, cfg_next;
    mtf_pkg::buf_ctrl_t         buf_ctrl;
    logic                       accept;
    logic                       phase_idle;
    logic                       buf_clr;
    logic [7:0]                 rd_data;
    logic [mtf_pkg::ADDR_W-1:0] rd_addr;
    logic [mtf_pkg::LEN_W-1:0]  loaded_count;

    assign accept = start && !busy;

    // Update configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx)
                mtf_pkg::REG_MIN_LENGTH:
                    cfg_next.min_length = cfg_wdata[mtf_pkg::MIN_LEN_W-1:0];
                mtf_pkg::REG_PREAMBLE:
                    cfg_next.preamble_nibbles = cfg_wdata[mtf_pkg::PRE_W-1:0];
                mtf_pkg::REG_GAP:
                    cfg_next.gap_nibbles = cfg_wdata[mtf_pkg::GAP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.min_length       <= mtf_pkg::MIN_LENGTH_RST;
            cfg_reg.preamble_nibbles <= mtf_pkg::PREAMBLE_RST;
            cfg_reg.gap_nibbles      <= mtf_pkg::GAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Append bytes only while no frame is in progress
    assign buf_ctrl.wr  = accept && (cmd == mtf_pkg::CMD_LOAD) && phase_idle;
    assign buf_ctrl.clr = buf_clr;

    mtf_frame_buf u_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (buf_ctrl),
        .wdata        (data_byte),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .loaded_count (loaded_count)
    );

    mtf_tx_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cmd          (cmd),
        .cfg          (cfg_reg),
        .loaded_count (loaded_count),
        .rd_data      (rd_data),
        .rd_addr      (rd_addr),
        .phase_idle   (phase_idle),
        .buf_clr      (buf_clr),
        .busy         (busy),
        .done         (done),
        .tx_en        (tx_en),
        .txd          (txd),
        .busy_res     (busy_res),
        .frame_end    (frame_end)
    );

endmodule
